// ===== sv/sgc_pkg.sv =====
`default_nettype none

package sgc_pkg;

  // Number of servo lanes and the width of a lane index.
  localparam int SERVO_SLOTS = 4;
  localparam int SLOT_W      = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;

  // Fixed field widths.
  localparam int PIN_W    = 4;
  localparam int OUT_LANES = 4;
  localparam int BTN_W    = 8;
  localparam int ANGLE_W  = 8;
  localparam int TIMER_W  = 24;
  localparam int SEL_W    = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Register reset values.
  localparam logic [TIMER_W-1:0] HOLD_TICKS_RST   = 24'd2000000;
  localparam logic [TIMER_W-1:0] REPEAT_TICKS_RST = 24'd250000;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST    = 8'd180;

  // Limit reset values.
  localparam logic [ANGLE_W-1:0] OPEN_LIMIT_RST   = 8'd80;
  localparam logic [ANGLE_W-1:0] CLOSED_LIMIT_RST = 8'd60;

  // Button bit positions.
  localparam int BTN_NEXT       = 0;
  localparam int BTN_PREV       = 1;
  localparam int BTN_INC_CLOSED = 2;
  localparam int BTN_DEC_CLOSED = 3;
  localparam int BTN_INC_OPEN   = 4;
  localparam int BTN_DEC_OPEN   = 5;
  localparam int BTN_CLOSE      = 6;
  localparam int BTN_OPEN       = 7;

  // Register word indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_HOLD_TICKS   = 2'd0,
    REG_REPEAT_TICKS = 2'd1,
    REG_ANGLE_MAX    = 2'd2
  } reg_idx_t;

  // Stored gate position of one servo.
  typedef enum logic [1:0] {
    POS_UNKNOWN = 2'd0,
    POS_CLOSED  = 2'd1,
    POS_OPENED  = 2'd2
  } pos_t;

  // Per-poll controls from the top level to one servo lane.
  typedef struct packed {
    logic advance;
    logic tick;
    logic want_open;
    logic inc_open;
    logic dec_open;
    logic inc_closed;
    logic dec_closed;
    logic cmd_open;
    logic cmd_close;
  } lane_ctl_t;

  // Status of one servo lane: current flags and the values after this poll.
  typedef struct packed {
    logic               attached;
    logic               hold_busy;
    logic               attached_nxt;
    logic [ANGLE_W-1:0] angle_nxt;
    logic [ANGLE_W-1:0] open_nxt;
    logic [ANGLE_W-1:0] closed_nxt;
  } lane_sts_t;

  // One result transaction.
  typedef struct packed {
    logic [OUT_LANES-1:0] servo_active;
    logic [ANGLE_W-1:0]   angle_zero;
    logic [ANGLE_W-1:0]   angle_one;
    logic [ANGLE_W-1:0]   angle_two;
    logic [ANGLE_W-1:0]   angle_three;
    logic [SEL_W-1:0]     selected_servo;
    logic [ANGLE_W-1:0]   selected_open_limit;
    logic [ANGLE_W-1:0]   selected_closed_limit;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/sgc_in_if.sv =====
`default_nettype none

interface sgc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      tick;
  logic [sgc_pkg::PIN_W-1:0] trigger_pins;
  logic [sgc_pkg::BTN_W-1:0] buttons;

  modport source (output valid, output tick, output trigger_pins, output buttons,
                  input ready);
  modport sink   (input valid, input tick, input trigger_pins, input buttons,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/sgc_out_if.sv =====
`default_nettype none

interface sgc_out_if;
  logic                          valid;
  logic                          ready;
  logic [sgc_pkg::OUT_LANES-1:0] servo_active;
  logic [sgc_pkg::ANGLE_W-1:0]   angle_zero;
  logic [sgc_pkg::ANGLE_W-1:0]   angle_one;
  logic [sgc_pkg::ANGLE_W-1:0]   angle_two;
  logic [sgc_pkg::ANGLE_W-1:0]   angle_three;
  logic [sgc_pkg::SEL_W-1:0]     selected_servo;
  logic [sgc_pkg::ANGLE_W-1:0]   selected_open_limit;
  logic [sgc_pkg::ANGLE_W-1:0]   selected_closed_limit;

  modport source (output valid, output servo_active, output angle_zero,
                  output angle_one, output angle_two, output angle_three,
                  output selected_servo, output selected_open_limit,
                  output selected_closed_limit, input ready);
  modport sink   (input valid, input servo_active, input angle_zero,
                  input angle_one, input angle_two, input angle_three,
                  input selected_servo, input selected_open_limit,
                  input selected_closed_limit, output ready);
endinterface

`default_nettype wire

// ===== sv/sgc_servo_lane.sv =====
`default_nettype none

// State of one servo: hold timer, attach flag, position, commanded angle and
// the two calibrated limits. One poll is applied per advance.
module sgc_servo_lane (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sgc_pkg::lane_ctl_t          ctl,
  input  wire logic [sgc_pkg::TIMER_W-1:0] hold_load,
  input  wire logic [sgc_pkg::ANGLE_W-1:0] angle_max,
  output sgc_pkg::lane_sts_t               sts
);

  logic [sgc_pkg::TIMER_W-1:0] hold_r, hold_nxt;
  logic                        att_r, att_nxt;
  sgc_pkg::pos_t               pos_r, pos_nxt;
  logic [sgc_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic [sgc_pkg::ANGLE_W-1:0] open_r, open_nxt;
  logic [sgc_pkg::ANGLE_W-1:0] closed_r, closed_nxt;

  always_comb begin
    hold_nxt   = hold_r;
    att_nxt    = att_r;
    pos_nxt    = pos_r;
    angle_nxt  = angle_r;
    open_nxt   = open_r;
    closed_nxt = closed_r;

    // Hold timer runs down first; reaching zero detaches the servo.
    if (ctl.tick && (hold_r != '0)) begin
      hold_nxt = hold_r - 1'b1;
      if (hold_r == sgc_pkg::TIMER_W'(1)) begin
        att_nxt = 1'b0;
      end
    end

    // Trigger pin against the stored position, using the limits before nudging.
    if (ctl.want_open && (pos_r != sgc_pkg::POS_OPENED)) begin
      att_nxt   = 1'b1;
      angle_nxt = open_r;
      hold_nxt  = hold_load;
      pos_nxt   = sgc_pkg::POS_OPENED;
    end else if (!ctl.want_open && (pos_r != sgc_pkg::POS_CLOSED)) begin
      att_nxt   = 1'b1;
      angle_nxt = closed_r;
      hold_nxt  = hold_load;
      pos_nxt   = sgc_pkg::POS_CLOSED;
    end

    // Calibration nudges: increment first, then decrement.
    if (ctl.inc_open && (open_nxt < angle_max)) begin
      open_nxt = open_nxt + 1'b1;
    end
    if (ctl.dec_open && (open_nxt != '0)) begin
      open_nxt = open_nxt - 1'b1;
    end
    if (ctl.inc_closed && (closed_nxt < angle_max)) begin
      closed_nxt = closed_nxt + 1'b1;
    end
    if (ctl.dec_closed && (closed_nxt != '0)) begin
      closed_nxt = closed_nxt - 1'b1;
    end

    // Panel commands use the nudged limits; close is applied last and wins.
    if (ctl.cmd_open) begin
      att_nxt   = 1'b1;
      angle_nxt = open_nxt;
      hold_nxt  = hold_load;
      pos_nxt   = sgc_pkg::POS_OPENED;
    end
    if (ctl.cmd_close) begin
      att_nxt   = 1'b1;
      angle_nxt = closed_nxt;
      hold_nxt  = hold_load;
      pos_nxt   = sgc_pkg::POS_CLOSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= '0;
      att_r    <= 1'b0;
      pos_r    <= sgc_pkg::POS_UNKNOWN;
      angle_r  <= '0;
      open_r   <= sgc_pkg::OPEN_LIMIT_RST;
      closed_r <= sgc_pkg::CLOSED_LIMIT_RST;
    end else if (ctl.advance) begin
      hold_r   <= hold_nxt;
      att_r    <= att_nxt;
      pos_r    <= pos_nxt;
      angle_r  <= angle_nxt;
      open_r   <= open_nxt;
      closed_r <= closed_nxt;
    end
  end

  always_comb begin
    sts.attached     = att_r;
    sts.hold_busy    = (hold_r != '0);
    sts.attached_nxt = att_nxt;
    sts.angle_nxt    = angle_nxt;
    sts.open_nxt     = open_nxt;
    sts.closed_nxt   = closed_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/servo_gate_controller_core.sv =====
// A poll accepted into the input register has its result written to the result register
// once that register is free, and out_ch.valid rises with it. Throughput: one poll per
// cycle while out_ch.ready stays high. A stalled receiver holds the result register and
// then the input register, so at most two polls wait before in_ch.ready drops.
// Reset (synchronous, rst_n low): registers return to their defaults, all servos
// detached with idle hold timers, positions unknown, limits 80 open and 60 closed.
`default_nettype none

module servo_gate_controller_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sgc_in_if.sink                           in_ch,
  sgc_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sgc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sgc_pkg::DATA_W-1:0]  pwdata,
  output logic      [sgc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int NS = sgc_pkg::SERVO_SLOTS;
  localparam int SW = sgc_pkg::SLOT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never waits, so a write lands at the
  // access cycle edge. The word index sits in paddr[3:2]; the unused fourth
  // word ignores writes and reads as zero.
  // ---------------------------------------------------------------------------
  logic [sgc_pkg::TIMER_W-1:0] hold_ticks_r;
  logic [sgc_pkg::TIMER_W-1:0] repeat_ticks_r;
  logic [sgc_pkg::ANGLE_W-1:0] angle_max_r;
  logic                        cfg_wr;
  sgc_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sgc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r   <= sgc_pkg::HOLD_TICKS_RST;
      repeat_ticks_r <= sgc_pkg::REPEAT_TICKS_RST;
      angle_max_r    <= sgc_pkg::ANGLE_MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sgc_pkg::REG_HOLD_TICKS:   hold_ticks_r   <= pwdata[sgc_pkg::TIMER_W-1:0];
        sgc_pkg::REG_REPEAT_TICKS: repeat_ticks_r <= pwdata[sgc_pkg::TIMER_W-1:0];
        sgc_pkg::REG_ANGLE_MAX:    angle_max_r    <= pwdata[sgc_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sgc_pkg::REG_HOLD_TICKS:   prdata = sgc_pkg::DATA_W'(hold_ticks_r);
      sgc_pkg::REG_REPEAT_TICKS: prdata = sgc_pkg::DATA_W'(repeat_ticks_r);
      sgc_pkg::REG_ANGLE_MAX:    prdata = sgc_pkg::DATA_W'(angle_max_r);
      default:                   prdata = '0;
    endcase
  end

  // A timer reload of zero behaves as one tick.
  logic [sgc_pkg::TIMER_W-1:0] hold_load;
  logic [sgc_pkg::TIMER_W-1:0] repeat_load;

  assign hold_load   = (hold_ticks_r == '0) ? sgc_pkg::TIMER_W'(1) : hold_ticks_r;
  assign repeat_load = (repeat_ticks_r == '0) ? sgc_pkg::TIMER_W'(1) : repeat_ticks_r;

  // ---------------------------------------------------------------------------
  // Two-register pipeline. The input register holds one accepted poll; it is
  // applied to the state and its result written to the result register when
  // the result register is empty or being drained in the same cycle. The
  // input side stays ready while the input register empties in this cycle.
  // ---------------------------------------------------------------------------
  logic                      a_valid_r;
  logic                      a_tick_r;
  logic [sgc_pkg::PIN_W-1:0] a_pins_r;
  logic [sgc_pkg::BTN_W-1:0] a_buttons_r;
  logic                      b_valid_r;
  sgc_pkg::result_t          res_r, res_nxt;
  logic                      advance;
  logic                      in_fire;

  assign advance     = a_valid_r && (!b_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (advance) begin
        a_valid_r <= 1'b0;
      end
      if (advance) begin
        b_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_tick_r    <= in_ch.tick;
      a_pins_r    <= in_ch.trigger_pins;
      a_buttons_r <= in_ch.buttons;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Button handling: auto-repeat timer, edge detection and servo selection.
  // When the repeat timer has run out the stored buttons count as released,
  // so every held button produces a fresh press.
  // ---------------------------------------------------------------------------
  logic [sgc_pkg::TIMER_W-1:0] repeat_r, repeat_nxt, repeat_dec;
  logic [sgc_pkg::BTN_W-1:0]   prev_buttons_r, prev_eff, changed, pressed;
  logic [SW-1:0]               cur_r, cur_base, cur_nxt;
  logic [SW:0]                 cur_inc;

  always_comb begin
    repeat_dec = repeat_r;
    if (a_tick_r && (repeat_r != '0)) begin
      repeat_dec = repeat_r - 1'b1;
    end
    prev_eff   = (repeat_dec == '0) ? '0 : prev_buttons_r;
    changed    = a_buttons_r ^ prev_eff;
    pressed    = a_buttons_r & changed;
    repeat_nxt = (changed != '0) ? repeat_load : repeat_dec;

    // Next and prev wrap around the populated slots; both together cancel.
    cur_base = ({1'b0, cur_r} >= (SW + 1)'(NS)) ? '0 : cur_r;
    cur_nxt  = cur_base;
    if (pressed[sgc_pkg::BTN_NEXT]) begin
      cur_inc = {1'b0, cur_nxt} + 1'b1;
      cur_nxt = (cur_inc >= (SW + 1)'(NS)) ? '0 : cur_inc[SW-1:0];
    end else begin
      cur_inc = '0;
    end
    if (pressed[sgc_pkg::BTN_PREV]) begin
      cur_nxt = (cur_nxt == '0) ? SW'(NS - 1) : cur_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r       <= '0;
      prev_buttons_r <= '0;
      cur_r          <= '0;
    end else if (advance) begin
      repeat_r       <= repeat_nxt;
      prev_buttons_r <= a_buttons_r;
      cur_r          <= cur_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Servo lanes. Each lane applies its hold timer, its trigger pin and the
  // panel actions aimed at it. Lanes past the trigger pins see a closed request.
  // ---------------------------------------------------------------------------
  sgc_pkg::lane_sts_t          sts      [NS];
  logic [sgc_pkg::ANGLE_W-1:0] open_vis [NS];
  logic [sgc_pkg::ANGLE_W-1:0] close_vis[NS];
  logic [NS-1:0]               att_vec;
  logic [NS-1:0]               busy_vec;

  for (genvar g = 0; g < NS; g++) begin : g_lane
    sgc_pkg::lane_ctl_t ctl;
    logic               sel;

    assign sel = (cur_nxt == SW'(g));

    if (g < sgc_pkg::PIN_W) begin : g_pin
      assign ctl.want_open = !a_pins_r[g];
    end else begin : g_nopin
      assign ctl.want_open = 1'b0;
    end

    assign ctl.advance    = advance;
    assign ctl.tick       = a_tick_r;
    assign ctl.inc_open   = sel && pressed[sgc_pkg::BTN_INC_OPEN];
    assign ctl.dec_open   = sel && pressed[sgc_pkg::BTN_DEC_OPEN];
    assign ctl.inc_closed = sel && pressed[sgc_pkg::BTN_INC_CLOSED];
    assign ctl.dec_closed = sel && pressed[sgc_pkg::BTN_DEC_CLOSED];
    assign ctl.cmd_open   = sel && pressed[sgc_pkg::BTN_OPEN];
    assign ctl.cmd_close  = sel && pressed[sgc_pkg::BTN_CLOSE];

    sgc_servo_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .hold_load (hold_load),
      .angle_max (angle_max_r),
      .sts       (sts[g])
    );

    assign open_vis[g]  = sts[g].open_nxt;
    assign close_vis[g] = sts[g].closed_nxt;
    assign att_vec[g]   = sts[g].attached;
    assign busy_vec[g]  = sts[g].hold_busy;
  end

  // Only the first four lanes are visible on the result; missing lanes read zero.
  logic [sgc_pkg::ANGLE_W-1:0] angle_vis[sgc_pkg::OUT_LANES];
  logic [sgc_pkg::OUT_LANES-1:0] active_vis;

  for (genvar g = 0; g < sgc_pkg::OUT_LANES; g++) begin : g_vis
    if (g < NS) begin : g_used
      assign angle_vis[g]  = sts[g].angle_nxt;
      assign active_vis[g] = sts[g].attached_nxt;
    end else begin : g_empty
      assign angle_vis[g]  = '0;
      assign active_vis[g] = 1'b0;
    end
  end

  always_comb begin
    res_nxt.servo_active          = active_vis;
    res_nxt.angle_zero            = angle_vis[0];
    res_nxt.angle_one             = angle_vis[1];
    res_nxt.angle_two             = angle_vis[2];
    res_nxt.angle_three           = angle_vis[3];
    res_nxt.selected_servo        = sgc_pkg::SEL_W'(cur_nxt);
    res_nxt.selected_open_limit   = open_vis[cur_nxt];
    res_nxt.selected_closed_limit = close_vis[cur_nxt];
  end

  assign out_ch.valid                 = b_valid_r;
  assign out_ch.servo_active          = res_r.servo_active;
  assign out_ch.angle_zero            = res_r.angle_zero;
  assign out_ch.angle_one             = res_r.angle_one;
  assign out_ch.angle_two             = res_r.angle_two;
  assign out_ch.angle_three           = res_r.angle_three;
  assign out_ch.selected_servo        = res_r.selected_servo;
  assign out_ch.selected_open_limit   = res_r.selected_open_limit;
  assign out_ch.selected_closed_limit = res_r.selected_closed_limit;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A servo is attached exactly while its hold timer runs.
  a_attach_matches_hold: assert property (@(posedge clk) disable iff (!rst_n)
    att_vec == busy_vec)
    else $error("attach flags disagree with running hold timers");

  // A new transaction never overwrites a poll that has not been applied.
  a_no_input_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && a_valid_r) |-> advance)
    else $error("input register overwritten before it was applied");

  // Stored buttons are only kept while the repeat timer runs.
  a_repeat_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (prev_buttons_r != '0) |-> (repeat_r != '0))
    else $error("held buttons stored with an expired repeat timer");

  // The selection always names a populated slot.
  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_r} < (SW + 1)'(NS))
    else $error("selected servo out of range");

endmodule

`default_nettype wire
